/* rtl/int_to_decimal_ascii_top_assert.svh */
// Assertion macros shared by the checker.
`ifndef INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2DA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2da assertion failed");

// Next-cycle implication, disabled during reset.
`define I2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2da assertion failed");

// Next-cycle implication that also holds across reset.
`define I2DA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("i2da assertion failed");

`endif

/* rtl/i2da_pkg.sv */
package i2da_pkg;

  localparam int WORD_W          = 32;
  localparam int DIGITS          = 10;
  localparam int BCD_W           = 4 * DIGITS;
  localparam int STEPS_PER_STAGE = 8;
  localparam int N_STAGES        = WORD_W / STEPS_PER_STAGE;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last;
  } out_t;

  // Working word of the shift-and-add-3 converter.
  typedef struct packed {
    logic              neg;
    logic [WORD_W-1:0] bin;
    logic [BCD_W-1:0]  bcd;
  } stage_t;

  // Several shift-and-add-3 steps: correct each digit, then shift in one binary bit.
  function automatic stage_t dabble_steps(stage_t s);
    stage_t r;
    r = s;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      for (int j = 0; j < DIGITS; j++) begin
        if (r.bcd[j*4 +: 4] >= 4'd5) begin
          r.bcd[j*4 +: 4] = r.bcd[j*4 +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[BCD_W-2:0], r.bin[WORD_W-1]};
      r.bin = {r.bin[WORD_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/int_to_decimal_ascii_top.sv */
// Converts a 32-bit word (unsigned, or two's complement when kind is 1) into
// its decimal ASCII text, one character per output transaction, most
// significant first: an optional '-' then 1 to 10 digits without leading
// zeros, the final character flagged by last. A transaction goes through a
// sign/negate stage, four shift-and-add-3 stages (8 bits each) and a
// character serializer before the output register. The serializer emits
// one character per cycle while the output is not stalled, so an item
// takes 1 to 11 output transactions (its text length); input
// transactions keep entering the pipeline every cycle while it has free
// stages, and in_stall rises once the pipeline backs up behind the
// serializer. Nothing is kept between items.
module int_to_decimal_ascii_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  i2da_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output i2da_pkg::out_t out_data
);

  localparam int NS = i2da_pkg::N_STAGES;

  // Pipeline stage 0 plus NS converter stages.
  logic             stg_valid [0:NS];
  i2da_pkg::stage_t stg       [0:NS];
  logic             adv       [0:NS];

  // Stage 0: sign detect and magnitude. Negation is exact for the most
  // negative value too, since the magnitude is read as unsigned.
  logic             s0_valid_r;
  i2da_pkg::stage_t s0_r;
  i2da_pkg::stage_t s0_nxt;

  always_comb begin
    s0_nxt.neg = in_data.kind & in_data.value[i2da_pkg::WORD_W-1];
    s0_nxt.bin = s0_nxt.neg ? (~in_data.value + 1'b1) : in_data.value;
    s0_nxt.bcd = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv[0]) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_r <= s0_nxt;
    end
  end

  assign stg_valid[0] = s0_valid_r;
  assign stg[0]       = s0_r;

  // Binary to BCD, 8 bits per stage.
  for (genvar k = 1; k <= NS; k++) begin : g_stage
    i2da_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv[k]),
      .up_valid (stg_valid[k-1]),
      .up       (stg[k-1]),
      .dn_valid (stg_valid[k]),
      .dn       (stg[k])
    );
  end

  // Backpressure: a stage moves when it is empty or the one after it moves.
  logic ser_free;

  assign adv[NS] = !stg_valid[NS] || ser_free;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !stg_valid[k] || adv[k+1];
  end

  assign in_stall = !adv[0];

  // Index of the most significant nonzero digit (0 for zero).
  logic [3:0] lead;

  always_comb begin
    lead = 4'd0;
    for (int j = 0; j < i2da_pkg::DIGITS; j++) begin
      if (stg[NS].bcd[j*4 +: 4] != 4'd0) begin
        lead = 4'(j);
      end
    end
  end

  // Serializer: holds one converted number and walks its digits down.
  logic                         ser_valid_r, ser_valid_nxt;
  logic                         ser_sign_r,  ser_sign_nxt;
  logic [i2da_pkg::BCD_W-1:0]   ser_bcd_r,   ser_bcd_nxt;
  logic [3:0]                   ser_idx_r,   ser_idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  i2da_pkg::out_t               out_data_r,  out_data_nxt;

  logic       out_load;
  logic       ser_done;
  logic [3:0] digit;

  assign out_load = !out_valid_r || !out_stall;
  assign ser_done = ser_valid_r && !ser_sign_r && (ser_idx_r == 4'd0);
  assign ser_free = !ser_valid_r || (out_load && ser_done);
  assign digit    = ser_bcd_r[{ser_idx_r, 2'b00} +: 4];

  always_comb begin
    ser_valid_nxt = ser_valid_r;
    ser_sign_nxt  = ser_sign_r;
    ser_bcd_nxt   = ser_bcd_r;
    ser_idx_nxt   = ser_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_load) begin
      out_valid_nxt = ser_valid_r;
      if (ser_sign_r) begin
        out_data_nxt.text_char = i2da_pkg::CHAR_MINUS;
        out_data_nxt.last      = 1'b0;
      end else begin
        out_data_nxt.text_char = i2da_pkg::CHAR_ZERO + {4'b0000, digit};
        out_data_nxt.last      = (ser_idx_r == 4'd0);
      end
      if (ser_valid_r) begin
        if (ser_sign_r) begin
          ser_sign_nxt = 1'b0;
        end else if (ser_done) begin
          ser_valid_nxt = 1'b0;
        end else begin
          ser_idx_nxt = ser_idx_r - 4'd1;
        end
      end
    end

    // pick up the next number as soon as the current one is finished
    if (ser_free && stg_valid[NS]) begin
      ser_valid_nxt = 1'b1;
      ser_sign_nxt  = stg[NS].neg;
      ser_bcd_nxt   = stg[NS].bcd;
      ser_idx_nxt   = lead;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_sign_r  <= 1'b0;
      ser_idx_r   <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      ser_valid_r <= ser_valid_nxt;
      ser_sign_r  <= ser_sign_nxt;
      ser_idx_r   <= ser_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ser_bcd_r  <= ser_bcd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/i2da_stage.sv */
module i2da_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             up_valid,
  input  i2da_pkg::stage_t up,
  output logic             dn_valid,
  output i2da_pkg::stage_t dn
);

  logic             valid_r;
  i2da_pkg::stage_t data_r;
  i2da_pkg::stage_t data_nxt;

  assign data_nxt = i2da_pkg::dabble_steps(up);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn       = data_r;

endmodule

/* rtl/i2da_checker.sv */
`include "int_to_decimal_ascii_top_assert.svh"

module i2da_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input i2da_pkg::out_t out_data
);

  // stalled output transaction holds
  `I2DA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // only '-' or a digit ever goes out
  `I2DA_ASSERT_NOW(a_char_range, clk, rst_n, out_valid, (out_data.text_char == i2da_pkg::CHAR_MINUS) || ((out_data.text_char >= i2da_pkg::CHAR_ZERO) && (out_data.text_char <= (i2da_pkg::CHAR_ZERO + 8'd9))))

  // a minus sign is always followed by digits
  `I2DA_ASSERT_NOW(a_minus_not_last, clk, rst_n, out_valid && (out_data.text_char == i2da_pkg::CHAR_MINUS), !out_data.last)

  // reset empties the output
  `I2DA_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind int_to_decimal_ascii_top i2da_checker u_i2da_checker (.*);

/* tb/int_to_decimal_ascii_checker.sv */
// Predicts the decimal text of every accepted word and compares it,
// character by character, with what the block emits.
module int_to_decimal_ascii_checker #(
  parameter logic SIGNED_KIND = 1'b1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  i2da_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  i2da_pkg::out_t out_data,
  output int             fail_count,
  output int             outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] RADIX = 32'd10;

  i2da_pkg::out_t expected_text[$];
  i2da_pkg::out_t want;
  int mismatches = 0;

  assign fail_count = mismatches;

  // Text of one word, most significant character first.
  function automatic void push_decimal_text(i2da_pkg::in_t item);
    logic [31:0]    mag;
    logic [3:0]     digit [10];
    int             n;
    i2da_pkg::out_t ch;
    mag = item.value;
    n = 0;
    if (item.kind == SIGNED_KIND && item.value[31]) begin
      mag = ~item.value + 32'd1;   // also exact for the most negative word
      ch.text_char = i2da_pkg::CHAR_MINUS;
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    do begin
      digit[n] = 4'(mag % RADIX);
      n++;
      mag = mag / RADIX;
    end while (mag != 32'd0);
    for (int i = n - 1; i >= 0; i--) begin
      ch.text_char = i2da_pkg::CHAR_ZERO + {4'd0, digit[i]};
      ch.last = (i == 0);
      expected_text.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_text.delete();
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        push_decimal_text(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          $error("text_char: expected none, actual %0d", out_data.text_char);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (out_data.text_char != want.text_char) begin
            $error("text_char: expected %0d, actual %0d", want.text_char, out_data.text_char);
            mismatches++;
          end
          if (out_data.last != want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_data.last);
            mismatches++;
          end
        end
      end
      outstanding <= expected_text.size();
    end
  end

endmodule

/* tb/tb_int_to_decimal_ascii_top.sv */
// Stimulus and verdict for int_to_decimal_ascii_top. Checking lives in the
// checker instance; this module only drives transactions and decides.
module tb_int_to_decimal_ascii_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_UNSIGNED = 1'b0;
  localparam logic KIND_SIGNED   = 1'b1;

  localparam int RANDOM_WORDS  = 440;
  localparam int STEADY_FIRST  = 150;  // window with no idling on either side
  localparam int STEADY_LAST   = 230;
  localparam int IDLE_PERCENT  = 26;
  localparam int SETTLE_CYCLES = 40;   // covers the pipeline with margin
  localparam int STUCK_LIMIT   = 2000; // cycles without any transaction

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  i2da_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  i2da_pkg::out_t out_data;

  logic steady = 1'b0;   // suppresses idling on both channels
  int   fail_count;
  int   outstanding;     // characters predicted but not yet seen
  int   stuck_cycles = 0;

  always #10 clk = ~clk;

  int_to_decimal_ascii_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  int_to_decimal_ascii_checker #(
    .SIGNED_KIND (KIND_SIGNED)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver: stalls about a quarter of the cycles, never in the steady window.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("int_to_decimal_ascii_top regression: fail");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // One transaction; returns at the edge where it is accepted, so the
  // caller may drive the next one (or drop valid) in that same step.
  task automatic send_word(input logic kind, input logic [31:0] value);
    in_data  <= {kind, value};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender holds off until every predicted character has come out.
  task automatic wait_text_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random idle gap before a transaction.
  task automatic maybe_idle();
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Value shapes chosen so that every text length and both signs turn up
  // often, not just the ten-digit words that a flat random draw favors.
  task automatic send_random_word();
    logic [31:0] value;
    logic [31:0] pow;
    pow = 32'd1;
    case ($urandom_range(0, 5))
      0: value = $urandom;
      1: value = $urandom_range(0, 9);
      2: begin
        // one below, at and one above a power of ten
        repeat ($urandom_range(0, 9)) pow = pow * 32'd10;
        value = pow + $urandom_range(0, 2) - 32'd1;
      end
      3: value = $urandom >> $urandom_range(0, 31);
      4: value = ~($urandom >> $urandom_range(0, 31)) + 32'd1;  // small negative
      default: begin
        case ($urandom_range(0, 3))
          0: value = 32'h0000_0000;
          1: value = 32'h8000_0000;
          2: value = 32'h7FFF_FFFF;
          default: value = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    send_word($urandom_range(0, 1) ? KIND_SIGNED : KIND_UNSIGNED, value);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, single digits, digit-count boundaries, sign handling.
    send_word(KIND_UNSIGNED, 32'd0);
    send_word(KIND_SIGNED,   32'd0);
    send_word(KIND_UNSIGNED, 32'd1);
    send_word(KIND_SIGNED,   32'd1);
    send_word(KIND_UNSIGNED, 32'd9);
    send_word(KIND_UNSIGNED, 32'd10);
    send_word(KIND_SIGNED,   32'd99);
    send_word(KIND_UNSIGNED, 32'd100);
    send_word(KIND_UNSIGNED, 32'd999_999_999);
    send_word(KIND_UNSIGNED, 32'd1_000_000_000);
    send_word(KIND_UNSIGNED, 32'd1_234_567_890);
    send_word(KIND_UNSIGNED, 32'h7FFF_FFFF);
    send_word(KIND_SIGNED,   32'h7FFF_FFFF);
    // most negative word: minus sign plus the full ten-digit magnitude
    send_word(KIND_SIGNED,   32'h8000_0000);
    // top bit set but unsigned: no sign, ten digits
    send_word(KIND_UNSIGNED, 32'h8000_0000);
    send_word(KIND_SIGNED,   32'h8000_0001);
    send_word(KIND_UNSIGNED, 32'hFFFF_FFFF);
    send_word(KIND_SIGNED,   32'hFFFF_FFFF);   // -1
    send_word(KIND_SIGNED,   32'hFFFF_FFF6);   // -10
    send_word(KIND_SIGNED,   32'hC465_3600);   // -1000000000, longest text

    // Let the pipeline empty completely before the random part.
    wait_text_drained();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady <= (i >= STEADY_FIRST) && (i < STEADY_LAST);
      maybe_idle();
      send_random_word();
    end

    steady <= 1'b0;
    wait_text_drained();
    // catch anything the block emits beyond the predicted text
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("int_to_decimal_ascii_top regression: pass");
    end else begin
      $display("int_to_decimal_ascii_top regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/i2da_pkg.sv
rtl/i2da_stage.sv
rtl/int_to_decimal_ascii_top.sv
rtl/i2da_checker.sv
tb/int_to_decimal_ascii_checker.sv
tb/tb_int_to_decimal_ascii_top.sv
